FILE: design/pve_pkg.sv
// shared types, constants and helpers for the pulse voice envelope writer
`timescale 1ns / 1ps
`default_nettype none

package pve_pkg;

    localparam int VOICES      = 4;
    localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SLOTS       = 3 * VOICES;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    localparam logic CFG_DUTY = 1'b0;
    localparam logic CFG_VIB  = 1'b1;

    // register offsets within one pulse voice
    localparam logic [1:0] OFS_CTRL = 2'd0;
    localparam logic [1:0] OFS_LO   = 2'd2;
    localparam logic [1:0] OFS_HI   = 2'd3;

    // envelope shapes and lfo steps
    localparam logic [1:0] SHAPE_PIANO = 2'd1;
    localparam logic [1:0] SHAPE_PLUCK = 2'd2;
    localparam logic [1:0] LFO_RISE    = 2'd1;
    localparam logic [1:0] LFO_FALL    = 2'd3;

    localparam logic [7:0]  CTRL_BASE  = 8'h30;
    localparam logic [7:0]  UNWRITTEN  = 8'hFF;
    localparam logic [15:0] REST_ENTRY = 16'h0000;

    typedef struct packed {
        logic [3:0]  note_flags;
        logic [15:0] entry_zero;
        logic [15:0] entry_one;
        logic [15:0] entry_two;
        logic [15:0] entry_three;
        logic        effect_busy;
    } item_t;

    typedef struct packed {
        logic [1:0] channel;
        logic [1:0] reg_offset;
        logic [7:0] data;
        logic       last;
    } result_t;

    // per-voice state seen by one lane
    typedef struct packed {
        logic [15:0] entry;
        logic [7:0]  age;
        logic        pending;
        logic [7:0]  wvol;
        logic [7:0]  whigh;
    } voice_state_t;

    // up to three writes found by one lane
    typedef struct packed {
        logic       ctrl_en;
        logic [7:0] ctrl_data;
        logic       lo_en;
        logic [7:0] lo_data;
        logic       hi_en;
        logic [7:0] hi_data;
    } lane_wr_t;

    typedef struct packed {
        logic             active;
        logic [CNT_W-1:0] remain;
    } merge_status_t;

    // velocity to base volume
    function automatic logic [3:0] vel_volume(input logic [1:0] vel);
        logic [3:0] vol;
        case (vel)
            2'd0:    vol = 4'd4;
            2'd1:    vol = 4'd6;
            2'd2:    vol = 4'd8;
            default: vol = 4'd10;
        endcase
        return vol;
    endfunction

endpackage

`default_nettype wire

FILE: design/pulse_voice_envelope_writer_unit.sv
// top level of the pulse voice envelope writer: frame state, voice lanes and merge stage
// path: a frame item passes the sequencer state register, the merge slot registers and the output register
// throughput: a new frame item is taken only once the merge stage has drained the writes of the last one,
//   scanning 3 write slots per voice, one slot a cycle while the result side does not stall
// reset: asynchronous active low; ages, entries, pending flags and lfo cleared,
//   volume and high-byte shadows set to 0xff, effect marked busy, config cleared
`timescale 1ns / 1ps
`default_nettype none

module pulse_voice_envelope_writer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // frame items
    input  logic                            item_valid,
    output logic                            item_stall,
    input  pve_pkg::item_t                  item,
    // register writes
    output logic                            result_valid,
    input  logic                            result_stall,
    output pve_pkg::result_t                result,
    // configuration
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [pve_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pve_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a frame item
    localparam logic [1:0] ST_LANE = 2'd1;   // lanes evaluate the frame
    localparam logic [1:0] ST_SEND = 2'd2;   // merge stage drains the writes

    logic [1:0]        state_reg;

    // configuration
    logic [7:0]        duty_reg;
    logic [VOICES-1:0] vib_reg;

    // per-voice frame state
    logic [7:0]        age_reg     [VOICES];
    logic [15:0]       entry_reg   [VOICES];
    logic [VOICES-1:0] pending_reg;
    logic [7:0]        wvol_reg    [VOICES];
    logic [7:0]        whigh_reg   [VOICES];

    // shared lfo and effect tracking
    logic [1:0]        lfo_count_reg;
    logic [1:0]        lfo_phase_reg;
    logic              was_busy_reg;
    logic              busy_reg;

    logic              accept;
    logic              fx_release;
    logic [15:0]       item_entry  [VOICES];
    voice_state_t      lane_st     [VOICES];
    logic [VOICES-1:0] lane_en;
    lane_wr_t [VOICES-1:0] lane_wr;
    logic [7:0]        lane_wvol   [VOICES];
    logic [7:0]        lane_whigh  [VOICES];
    merge_status_t     merge_status;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign fx_release = was_busy_reg && !item.effect_busy;

    assign item_entry[0] = item.entry_zero;
    assign item_entry[1] = item.entry_one;
    assign item_entry[2] = item.entry_two;
    assign item_entry[3] = item.entry_three;

    // lane inputs; voice 1 stays silent while an effect owns it
    always_comb
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            lane_st[v].entry   = entry_reg[v];
            lane_st[v].age     = age_reg[v];
            lane_st[v].pending = pending_reg[v];
            lane_st[v].wvol    = wvol_reg[v];
            lane_st[v].whigh   = whigh_reg[v];
            lane_en[v]         = !((v == 1) && busy_reg);
        end
    end

    // one lane per pulse voice, all evaluated in the same cycle
    for (genvar gv = 0; gv < VOICES; gv++)
    begin : g_lane
        pve_lane u_lane (
            .st         (lane_st[gv]),
            .duty       (duty_reg[2*gv +: 2]),
            .vib_en     (vib_reg[gv]),
            .lfo_phase  (lfo_phase_reg),
            .lfo_count  (lfo_count_reg),
            .enable     (lane_en[gv]),
            .wr         (lane_wr[gv]),
            .wvol_next  (lane_wvol[gv]),
            .whigh_next (lane_whigh[gv])
        );
    end

    // merge stage serialises the lane writes into transfers
    pve_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (state_reg == ST_LANE),
        .wr        (lane_wr),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .out_data  (result),
        .status    (merge_status)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
            vib_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DUTY: duty_reg <= cfg_data;
                CFG_VIB:  vib_reg  <= cfg_data[VOICES-1:0];
                default:  ;
            endcase
        end
    end

    // frame sequencer and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= '0;
            lfo_count_reg <= 2'd0;
            lfo_phase_reg <= 2'd0;
            was_busy_reg  <= 1'b1;
            busy_reg      <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                age_reg[v]   <= 8'd0;
                entry_reg[v] <= 16'd0;
                wvol_reg[v]  <= UNWRITTEN;
                whigh_reg[v] <= UNWRITTEN;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // envelope clocks advance, new notes restart them
                        for (int v = 0; v < VOICES; v++)
                        begin
                            if (item.note_flags[v])
                            begin
                                age_reg[v]   <= 8'd0;
                                entry_reg[v] <= item_entry[v];
                            end
                            else if (age_reg[v] != 8'hFF)
                            begin
                                age_reg[v] <= age_reg[v] + 8'd1;
                            end
                            // new note, or voice 1 released by the effect
                            if (item.note_flags[v] || ((v == 1) && fx_release))
                                pending_reg[v] <= 1'b1;
                        end
                        // three-frame lfo tick, a stray count of 3 wraps too
                        if (lfo_count_reg >= 2'd2)
                        begin
                            lfo_count_reg <= 2'd0;
                            lfo_phase_reg <= lfo_phase_reg + 2'd1;
                        end
                        else
                        begin
                            lfo_count_reg <= lfo_count_reg + 2'd1;
                        end
                        // effect released: voice 1 gets a full rewrite
                        if (fx_release)
                        begin
                            wvol_reg[1]    <= UNWRITTEN;
                            whigh_reg[1]   <= UNWRITTEN;
                        end
                        was_busy_reg <= item.effect_busy;
                        busy_reg     <= item.effect_busy;
                        state_reg    <= ST_LANE;
                    end
                end
                ST_LANE:
                begin
                    // shadows follow the writes, a skipped busy voice keeps its pending flag
                    for (int v = 0; v < VOICES; v++)
                    begin
                        wvol_reg[v]  <= lane_wvol[v];
                        whigh_reg[v] <= lane_whigh[v];
                        if (lane_en[v])
                            pending_reg[v] <= 1'b0;
                    end
                    state_reg <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (!merge_status.active)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no new frame while the merge stage still holds writes
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !merge_status.active)
        else $error("frame transfer while merge stage busy");

    // the lane cycle always hands a frame to the merge stage
    a_lane_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LANE) |=> merge_status.active)
        else $error("merge stage not started after lane cycle");

    // a write that is not the last one still has writes behind it
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (merge_status.active && (merge_status.remain != '0)))
        else $error("write without last flag but nothing left to send");

endmodule

`default_nettype wire

FILE: design/pve_lane.sv
// one voice lane: envelope, vibrato and the writes that voice needs
`timescale 1ns / 1ps
`default_nettype none

module pve_lane (
    input  pve_pkg::voice_state_t st,
    input  logic [1:0]            duty,
    input  logic                  vib_en,
    input  logic [1:0]            lfo_phase,
    input  logic [1:0]            lfo_count,
    input  logic                  enable,
    output pve_pkg::lane_wr_t     wr,
    output logic [7:0]            wvol_next,
    output logic [7:0]            whigh_next
);
    import pve_pkg::*;

    logic [3:0]  base;
    logic [1:0]  shape;
    logic        attack;
    logic [3:0]  rise;
    logic [7:0]  age_eff;
    logic [7:0]  drop_piano;
    logic [7:0]  drop_pluck;
    logic [7:0]  vol;
    logic [10:0] per;
    logic [3:0]  depth;
    logic [11:0] per_shift;
    logic        vib_ok;
    logic [10:0] per_out;
    logic        redo;
    logic [7:0]  hi;

    // envelope
    always_comb
    begin
        base       = vel_volume(st.entry[12:11]);
        shape      = st.entry[14:13];
        attack     = st.entry[15] && (st.age < 8'd4);
        rise       = {1'b0, st.age[1:0], 1'b0} + 4'd2;
        age_eff    = st.entry[15] ? (st.age - 8'd4) : st.age;
        drop_piano = age_eff >> 3;
        drop_pluck = age_eff >> 1;
        if (attack)
        begin
            vol = {4'd0, (rise < base) ? rise : base};
        end
        else
        begin
            case (shape)
                SHAPE_PIANO:
                begin
                    if ({1'b0, drop_piano} + 9'd1 >= {5'd0, base})
                        vol = 8'd1;
                    else
                        vol = {4'd0, base} - drop_piano;
                end
                SHAPE_PLUCK:
                begin
                    if (drop_pluck >= {4'd0, base})
                        vol = 8'd0;
                    else
                        vol = {4'd0, base} - drop_pluck;
                end
                default: vol = {4'd0, base};
            endcase
        end
    end

    // vibrato, kept inside the current high byte
    always_comb
    begin
        per   = st.entry[10:0];
        depth = {1'b0, per[10:8]} + 4'd1;
        case (lfo_phase)
            LFO_RISE: per_shift = {1'b0, per} + {8'd0, depth};
            LFO_FALL: per_shift = {1'b0, per} - {8'd0, depth};
            default:  per_shift = {1'b0, per};
        endcase
        vib_ok  = vib_en && (per_shift[10:8] == per[10:8]);
        per_out = vib_ok ? per_shift[10:0] : per;
        redo    = st.pending || (vib_ok && (lfo_count == 2'd0));
        hi      = {5'd0, per_out[10:8]};
    end

    // writes and register shadow updates
    always_comb
    begin
        wr         = '0;
        wvol_next  = st.wvol;
        whigh_next = st.whigh;
        if (enable)
        begin
            if (st.entry == REST_ENTRY)
            begin
                if (st.pending)
                begin
                    wr.ctrl_en   = 1'b1;
                    wr.ctrl_data = CTRL_BASE;
                    wvol_next    = 8'd0;
                end
            end
            else
            begin
                if (redo || (vol != st.wvol))
                begin
                    wr.ctrl_en   = 1'b1;
                    wr.ctrl_data = {duty, 6'd0} | CTRL_BASE | vol;
                    wvol_next    = vol;
                end
                if (redo)
                begin
                    wr.lo_en   = 1'b1;
                    wr.lo_data = per_out[7:0];
                    if (hi != st.whigh)
                    begin
                        wr.hi_en   = 1'b1;
                        wr.hi_data = hi;
                        whigh_next = hi;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pve_merge.sv
// merge stage: holds the lane writes and sends them one per transfer in voice order
`timescale 1ns / 1ps
`default_nettype none

module pve_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  pve_pkg::lane_wr_t [pve_pkg::VOICES-1:0] wr,
    input  logic                                    out_stall,
    output logic                                    out_valid,
    output pve_pkg::result_t                        out_data,
    output pve_pkg::merge_status_t                  status
);
    import pve_pkg::*;

    logic [VOICES-1:0][2:0] load_en;
    logic [VOICES-1:0][2:0] slot_en_reg;
    logic [7:0]             slot_data_reg [VOICES][3];
    logic [VOICE_W-1:0]     voice_reg;
    logic [1:0]             sub_reg;
    logic [CNT_W-1:0]       remain_reg;
    logic                   active_reg;
    logic                   out_valid_reg;
    result_t                out_data_reg;

    logic       cur_en;
    logic       out_free;
    logic       step;
    logic       emit;
    logic       last_slot;
    logic [1:0] ofs;

    always_comb
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            load_en[v] = {wr[v].hi_en, wr[v].lo_en, wr[v].ctrl_en};
        end
    end

    always_comb
    begin
        cur_en    = slot_en_reg[voice_reg][sub_reg];
        out_free  = !out_valid_reg || !out_stall;
        step      = active_reg && (!cur_en || out_free);
        emit      = step && cur_en;
        last_slot = (voice_reg == VOICE_W'(VOICES - 1)) && (sub_reg == 2'd2);
        case (sub_reg)
            2'd0:    ofs = OFS_CTRL;
            2'd1:    ofs = OFS_LO;
            default: ofs = OFS_HI;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_en_reg   <= '0;
            active_reg    <= 1'b0;
            voice_reg     <= '0;
            sub_reg       <= 2'd0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                slot_en_reg <= load_en;
                active_reg  <= 1'b1;
                voice_reg   <= '0;
                sub_reg     <= 2'd0;
                remain_reg  <= CNT_W'($countones(load_en));
            end
            else if (step)
            begin
                if (last_slot)
                begin
                    active_reg <= 1'b0;
                end
                else if (sub_reg == 2'd2)
                begin
                    sub_reg   <= 2'd0;
                    voice_reg <= voice_reg + VOICE_W'(1);
                end
                else
                begin
                    sub_reg <= sub_reg + 2'd1;
                end
                if (emit)
                begin
                    remain_reg <= remain_reg - CNT_W'(1);
                end
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                slot_data_reg[v][0] <= wr[v].ctrl_data;
                slot_data_reg[v][1] <= wr[v].lo_data;
                slot_data_reg[v][2] <= wr[v].hi_data;
            end
        end
        if (emit)
        begin
            out_data_reg.channel    <= 2'(voice_reg);
            out_data_reg.reg_offset <= ofs;
            out_data_reg.data       <= slot_data_reg[voice_reg][sub_reg];
            out_data_reg.last       <= (remain_reg == CNT_W'(1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign status.active = active_reg;
    assign status.remain = remain_reg;

endmodule

`default_nettype wire
